// File: design/riff_chunk_walker_core_macros.svh
// ----------------------------------------------------------------------------
// riff_chunk_walker_core_macros.svh
// Assertion macros shared by the chunk walker checker.
// ----------------------------------------------------------------------------
`ifndef RIFF_CHUNK_WALKER_CORE_MACROS_SVH
`define RIFF_CHUNK_WALKER_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset
`define RCW_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset
`define RCW_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rcw_pkg.sv
// ----------------------------------------------------------------------------
// rcw_pkg
// Item types and chunk ID constants for the RIFF chunk walker.
// ----------------------------------------------------------------------------
package rcw_pkg;

    // Input item: one byte of the wrapper buffer
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } rcw_in_t;

    // Result item: one reported chunk
    typedef struct packed {
        logic [23:0] chunk_offset;
        logic [23:0] chunk_size;
    } rcw_out_t;

    // Walker report toward the output register
    typedef struct packed {
        logic     valid;
        rcw_out_t data;
    } rcw_report_t;

    // Chunk IDs as little-endian 32-bit words
    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_RF64 = 32'h3436_4652;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;
    localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
    localparam logic [31:0] ID_DS64 = 32'h3436_7364;
    localparam logic [31:0] ID_JUNK = 32'h4b4e_554a;

    // Header length and the extra skip after a RIFF/RF64 header
    localparam int unsigned HDR_LEN   = 8;
    localparam int unsigned RIFF_SKIP = 4;

    localparam logic [23:0] POS_MAX = 24'hff_ffff;

endpackage

// File: design/rcw_walker.sv
// ----------------------------------------------------------------------------
// rcw_walker
// Walk state and header decode: consumes one byte per step and reports
// chunks by header offset and total size.
// ----------------------------------------------------------------------------
module rcw_walker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  rcw_pkg::rcw_in_t     item,
    input  logic [23:0]          buffer_length,
    output rcw_pkg::rcw_report_t report
);
    import rcw_pkg::*;

    logic [23:0] pos_reg,     pos_next;
    logic [55:0] hdr_reg,     hdr_next;
    logic [2:0]  count_reg,   count_next;
    logic [23:0] start_reg,   start_next;
    logic [24:0] skip_reg,    skip_next;
    logic        stopped_reg, stopped_next;

    logic [24:0] hdr_end;
    logic        start_ok;
    logic [23:0] left;
    logic [31:0] id;
    logic [31:0] size;
    logic [24:0] total;
    logic        overrun;
    logic        listed;

    // Header checks on the current position and gathered bytes
    assign hdr_end  = {1'b0, pos_reg} + 25'(HDR_LEN);
    assign start_ok = hdr_end <= {1'b0, buffer_length};
    assign left     = (buffer_length > start_reg) ? buffer_length - start_reg : 24'd0;
    assign id       = hdr_reg[31:0];
    assign size     = {item.data_byte, hdr_reg[55:32]};
    assign total    = {1'b0, size[23:0]} + 25'(HDR_LEN);
    assign overrun  = (size[31:24] != 8'd0) || (total > {1'b0, left});
    assign listed   = (id == ID_FMT) || (id == ID_DS64) || (id == ID_JUNK);

    // Advance the walk by one byte
    always_comb begin
        pos_next     = pos_reg;
        hdr_next     = hdr_reg;
        count_next   = count_reg;
        start_next   = start_reg;
        skip_next    = skip_reg;
        stopped_next = stopped_reg;
        report.valid = 1'b0;
        report.data  = '{chunk_offset: start_reg, chunk_size: total[23:0]};
        if (step) begin
            if (!stopped_reg) begin
                if (skip_reg != 25'd0) begin
                    skip_next = skip_reg - 25'd1;
                end else if ((count_reg == 3'd0) && !start_ok) begin
                    stopped_next = 1'b1;
                end else begin
                    if (count_reg == 3'd0) begin
                        start_next = pos_reg;
                    end
                    for (int k = 0; k < 7; k++) begin
                        if (count_reg == 3'(k)) begin
                            hdr_next[8*k +: 8] = item.data_byte;
                        end
                    end
                    count_next = count_reg + 3'd1;
                    // Full header: decode it
                    if (count_reg == 3'd7) begin
                        priority if ((id == ID_RIFF) || (id == ID_RF64)) begin
                            skip_next = 25'(RIFF_SKIP);
                        end else if (id == ID_DATA) begin
                            skip_next = 25'd0;
                        end else if (overrun) begin
                            stopped_next = 1'b1;
                        end else begin
                            report.valid = !listed;
                            skip_next    = {1'b0, size[23:0]} + 25'(size[0]);
                        end
                    end
                end
            end
            if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + 24'd1;
            end
            // Drop all walk state after the final byte
            if (item.last_byte) begin
                pos_next     = 24'd0;
                count_next   = 3'd0;
                start_next   = 24'd0;
                skip_next    = 25'd0;
                stopped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= 24'd0;
            count_reg   <= 3'd0;
            start_reg   <= 24'd0;
            skip_reg    <= 25'd0;
            stopped_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            count_reg   <= count_next;
            start_reg   <= start_next;
            skip_reg    <= skip_next;
            stopped_reg <= stopped_next;
        end
    end

    // Header bytes are rewritten before each read
    always_ff @(posedge aclk) begin
        hdr_reg <= hdr_next;
    end

endmodule

// File: design/riff_chunk_walker_core.sv
// ----------------------------------------------------------------------------
// riff_chunk_walker_core
// Walks RIFF chunk headers in a byte stream and reports each data-bearing
// chunk by header offset and total size.
//
//   channel   ports                     payload
//   -------   -----------------------   -------------------------------
//   input     s_valid/s_ready/s_item    data_byte, last_byte
//   result    m_valid/m_ready/m_item    chunk_offset, chunk_size
//   config    cfg_valid/cfg_ready       cfg_data = buffer_length
//
// One item per cycle unless the result register stalls; a byte lands in
// the input register when accepted and its result, if any, is loaded into
// the result register when the walk stage steps on that byte.
// Reset clears the walk state, the buffer length and both valid flags.
// A stalled result holds the walk stage; the input register takes a new
// item whenever the walk stage moves on in the same cycle.
// ----------------------------------------------------------------------------
module riff_chunk_walker_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rcw_pkg::rcw_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output rcw_pkg::rcw_out_t m_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [23:0]       cfg_data
);
    import rcw_pkg::*;

    logic        in_valid_reg,  in_valid_next;
    rcw_in_t     in_item_reg,   in_item_next;
    logic        out_valid_reg, out_valid_next;
    rcw_out_t    out_item_reg,  out_item_next;
    logic [23:0] blen_reg,      blen_next;

    logic        out_free;
    logic        step;
    rcw_report_t report;

    assign out_free  = !out_valid_reg || m_ready;
    assign step      = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_item_reg;

    rcw_walker u_walker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .item          (in_item_reg),
        .buffer_length (blen_reg),
        .report        (report)
    );

    // Capture items, load results, take register writes
    always_comb begin
        in_valid_next  = in_valid_reg;
        in_item_next   = in_item_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        blen_next      = blen_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_item_next  = s_item;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        if (step && report.valid) begin
            out_valid_next = 1'b1;
            out_item_next  = report.data;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (cfg_valid && cfg_ready) begin
            blen_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            blen_reg      <= 24'd0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            blen_reg      <= blen_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

endmodule

// File: design/rcw_checker.sv
// ----------------------------------------------------------------------------
// rcw_checker
// Port-level checks on the chunk walker, bound to the top level.
// ----------------------------------------------------------------------------
`include "riff_chunk_walker_core_macros.svh"

module rcw_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input rcw_pkg::rcw_out_t m_item
);
    import rcw_pkg::*;

    // A stalled result stays put
    `RCW_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_item), "result dropped or changed under stall")

    // Every reported chunk carries at least its header
    `RCW_ASSERT_NOW(a_size_min, m_valid, m_item.chunk_size >= 24'd8, "chunk size below header length")

    // A reported chunk ends inside the 24-bit buffer space
    `RCW_ASSERT_NOW(a_chunk_end, m_valid, (25'(m_item.chunk_offset) + 25'(m_item.chunk_size)) <= 25'h0ff_ffff, "chunk runs past buffer space")

    // Reset leaves no result pending
    `RCW_ASSERT_NOW(a_reset_empty, $rose(aresetn), !m_valid, "result valid right after reset")

endmodule

bind riff_chunk_walker_core rcw_checker u_rcw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

// File: tb/riff_walk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riff_walk_checker
// Watches the byte, result and length channels of the chunk walker, tracks
// the walk on its own copy of the state and compares every reported chunk
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module riff_walk_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  rcw_pkg::rcw_in_t  s_item,
    input  logic              m_valid,
    input  logic              m_ready,
    input  rcw_pkg::rcw_out_t m_item,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [23:0]       cfg_data,
    output int                mismatch_count,
    output int                pending_results
);
    import rcw_pkg::*;

    // Predicted walk state and the buffer length register
    bit [23:0] buf_len;
    bit [23:0] byte_pos;
    bit [63:0] hdr_bytes;
    bit [3:0]  hdr_count;
    bit [23:0] hdr_start;
    bit [24:0] skip_left;
    bit        stopped;

    rcw_out_t  expected_chunks[$];
    int        errors;

    function automatic void clear_walk();
        byte_pos  = '0;
        hdr_bytes = '0;
        hdr_count = '0;
        hdr_start = '0;
        skip_left = '0;
        stopped   = 1'b0;
    endfunction

    // Decode a full 8-byte header; return 1 when the chunk gets reported
    function automatic bit close_header(output rcw_out_t chunk);
        bit [31:0] id;
        bit [32:0] total;
        bit [23:0] left;
        id           = hdr_bytes[31:0];
        total        = {1'b0, hdr_bytes[63:32]} + 33'd8;
        hdr_count    = '0;
        hdr_bytes    = '0;
        chunk        = '0;
        close_header = 1'b0;
        if (id == ID_RIFF || id == ID_RF64) begin
            skip_left = 25'(RIFF_SKIP);
            return 1'b0;
        end
        if (id == ID_DATA) begin
            skip_left = '0;
            return 1'b0;
        end
        left = (buf_len > hdr_start) ? buf_len - hdr_start : 24'd0;
        // a size that wraps past 32 bits counts as an overrun
        if (total[32] || total > {9'd0, left}) begin
            stopped = 1'b1;
            return 1'b0;
        end
        if (id != ID_FMT && id != ID_DS64 && id != ID_JUNK) begin
            chunk.chunk_offset = hdr_start;
            chunk.chunk_size   = total[23:0];
            close_header       = 1'b1;
        end
        // pad to an even length, then skip the body
        if (total[0])
            total = total + 33'd1;
        total     = total - HDR_LEN;
        skip_left = total[24:0];
    endfunction

    // Advance the walk by one byte; return 1 when a chunk is reported
    function automatic bit advance_walk(input rcw_in_t it, output rcw_out_t chunk);
        bit [63:0] wide;
        advance_walk = 1'b0;
        chunk        = '0;
        if (!stopped) begin
            if (skip_left != 0) begin
                skip_left = skip_left - 25'd1;
            end else begin
                if (hdr_count == 0) begin
                    if ({1'b0, byte_pos} + 25'd8 > {1'b0, buf_len})
                        stopped = 1'b1;
                    else
                        hdr_start = byte_pos;
                end
                if (!stopped) begin
                    wide      = {56'd0, it.data_byte};
                    hdr_bytes = hdr_bytes | (wide << (8 * hdr_count[2:0]));
                    hdr_count = hdr_count + 4'd1;
                    if (hdr_count >= HDR_LEN)
                        advance_walk = close_header(chunk);
                end
            end
        end
        if (byte_pos != POS_MAX)
            byte_pos = byte_pos + 24'd1;
        if (it.last_byte)
            clear_walk();
    endfunction

    // Track every handshake: length writes, then results, then bytes
    always @(posedge aclk) begin : track
        rcw_out_t want;
        rcw_out_t chunk;
        if (!aresetn) begin
            buf_len = '0;
            clear_walk();
            expected_chunks.delete();
            errors = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                buf_len = cfg_data;
            if (m_valid && m_ready) begin
                if (expected_chunks.size() == 0) begin
                    $display("%0t: unexpected chunk: offset %0d size %0d",
                             $time, m_item.chunk_offset, m_item.chunk_size);
                    errors++;
                end else begin
                    want = expected_chunks.pop_front();
                    if (m_item.chunk_offset !== want.chunk_offset) begin
                        $display("%0t: chunk_offset: expected %0d, got %0d",
                                 $time, want.chunk_offset, m_item.chunk_offset);
                        errors++;
                    end
                    if (m_item.chunk_size !== want.chunk_size) begin
                        $display("%0t: chunk_size: expected %0d, got %0d",
                                 $time, want.chunk_size, m_item.chunk_size);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (advance_walk(s_item, chunk))
                    expected_chunks.insert(expected_chunks.size(), chunk);
            end
        end
        mismatch_count  <= errors;
        pending_results <= expected_chunks.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds RIFF wrapper buffers byte by byte into the chunk walker, mostly
// well-formed chunk sequences with random sizes and IDs plus broken and
// noise buffers, under varying source gaps and sink stalls. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import rcw_pkg::*;

    localparam logic [31:0] ID_LIST     = 32'h5453_494c;
    localparam int          ITEM_GOAL   = 900;
    localparam int          HOLD_CYCLES = 300;
    localparam int          QUIET_LIMIT = 2000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    rcw_in_t     s_item    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    rcw_out_t    m_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data  = '0;

    int          mismatch_count;
    int          pending_results;

    int          items_sent     = 0;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    logic        stall_burst    = 1'b0;
    int          src_pcts[4]    = '{0, 52, 0, 30};
    int          sink_pcts[4]   = '{0, 0, 52, 30};
    bit [7:0]    wrapper_bytes[$];

    always #2 aclk = ~aclk;

    riff_chunk_walker_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    riff_walk_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item          (s_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item          (m_item),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // Append one byte to the buffer being built
    function automatic void add_byte(input bit [7:0] b);
        wrapper_bytes.insert(wrapper_bytes.size(), b);
    endfunction

    // Buffer builders: words go out little-endian
    function automatic void add_word(input bit [31:0] w);
        for (int k = 0; k < 4; k++)
            add_byte(w[8*k +: 8]);
    endfunction

    function automatic void add_chunk(input bit [31:0] id, input bit [31:0] size, input int body);
        add_word(id);
        add_word(size);
        repeat (body) add_byte(8'($urandom_range(255)));
        if (body % 2 == 1)
            add_byte(8'($urandom_range(255)));
    endfunction

    function automatic void add_random_chunk();
        int body;
        body = $urandom_range(0, 24);
        case ($urandom_range(11))
            0: add_chunk(ID_FMT, body, body);
            1: add_chunk(ID_DS64, body, body);
            2: add_chunk(ID_JUNK, body, body);
            3: begin
                add_word(ID_DATA);
                add_word($urandom);
            end
            4: begin
                add_word($urandom_range(1) ? ID_RIFF : ID_RF64);
                add_word($urandom);
                add_word($urandom);
            end
            // size field that wraps when the header length is added
            5: add_chunk($urandom, 32'hffff_fff8 + $urandom_range(7), 0);
            // chunk larger than what is left of the buffer
            6: add_chunk($urandom, $urandom_range(1) ? $urandom : $urandom_range(40, 100000),
                         body);
            default: add_chunk($urandom, body, body);
        endcase
    endfunction

    function automatic void build_wrapper();
        int pick;
        wrapper_bytes.delete();
        pick = $urandom_range(9);
        if (pick == 0) begin
            repeat ($urandom_range(1, 40)) add_byte(8'($urandom_range(255)));
            return;
        end
        if (pick != 1) begin
            add_word($urandom_range(1) ? ID_RIFF : ID_RF64);
            add_word($urandom);
            add_word($urandom);
        end
        repeat ($urandom_range(1, 6)) add_random_chunk();
        repeat ($urandom_range(0, 9)) add_byte(8'($urandom_range(255)));
    endfunction

    // Mostly the true length, sometimes off by a few bytes, random or at the extremes
    function automatic bit [23:0] pick_length(input int exact);
        case ($urandom_range(15))
            0: return 24'd0;
            1: return 24'hff_ffff;
            2: return 24'($urandom);
            3: return 24'(exact + int'($urandom_range(8)));
            4: return (exact > 8) ? 24'(exact - int'($urandom_range(8))) : 24'd0;
            default: return 24'(exact);
        endcase
    endfunction

    // Offer one byte, with random gaps ahead of it, and hold until taken
    task automatic push_byte(input bit [7:0] b, input bit last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= '{data_byte: b, last_byte: last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Stop offering and wait until every predicted chunk has come out
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_length(input bit [23:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Send the built buffer, optionally retuning the length partway through
    task automatic send_wrapper(input bit [23:0] len, input bit retune);
        int cut;
        cut = retune ? int'($urandom_range(wrapper_bytes.size() - 1)) : -1;
        drain();
        write_length(len);
        foreach (wrapper_bytes[i]) begin
            if (i == cut) begin
                drain();
                write_length(pick_length(wrapper_bytes.size()));
            end
            push_byte(wrapper_bytes[i], i == wrapper_bytes.size() - 1);
        end
    endtask

    // Sink: random stalls, plus one long hold-off on request
    initial begin : sink
        bit held;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_burst && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int phase;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero length: the first header start is already past the end
        wrapper_bytes.delete();
        add_byte(8'hff);
        send_wrapper(24'd0, 1'b0);

        // full length, but the size field wraps past 32 bits
        wrapper_bytes.delete();
        add_chunk(ID_LIST, 32'hffff_ffff, 0);
        send_wrapper(24'hff_ffff, 1'b0);

        // data header, then an odd-sized reported chunk with its pad byte
        wrapper_bytes.delete();
        add_word(ID_DATA);
        add_word(32'h0000_0000);
        add_chunk(ID_LIST, 32'd1, 1);
        send_wrapper(24'd18, 1'b0);

        // long sink hold-off while the source keeps offering reported chunks
        drain();
        stall_burst <= 1'b1;
        wrapper_bytes.delete();
        repeat (12) add_chunk(ID_LIST, 32'd2, 2);
        send_wrapper(24'(wrapper_bytes.size()), 1'b0);

        // random buffers across the idling phases
        while (items_sent < ITEM_GOAL) begin
            phase          = (items_sent / 240) % 4;
            src_idle_pct   = src_pcts[phase];
            sink_stall_pct = sink_pcts[phase];
            build_wrapper();
            send_wrapper(pick_length(wrapper_bytes.size()), $urandom_range(5) == 0);
        end

        drain();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
